// ----- hdl/tgrr_pkg.sv -----
// Shared types and constants for the two-group round-robin task scheduler.
// Used by tgrr_timer, tgrr_group and the top level; depends on nothing.
package tgrr_pkg;

  // Slots in each group; slot code SLOTS_PER_GROUP marks an empty age entry
  localparam int SLOTS_PER_GROUP = 5;
  localparam int SLOT_W = $clog2(SLOTS_PER_GROUP + 1);
  localparam int PERIOD_W = 16;

  localparam logic [PERIOD_W-1:0] ADMIT_PERIOD_RESET = PERIOD_W'(401);
  localparam logic [PERIOD_W-1:0] EVICT_PERIOD_RESET = PERIOD_W'(2001);

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t SLOT_EMPTY = SLOT_W'(SLOTS_PER_GROUP);

  // Item operation codes
  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_ADMIT_PERIOD = 1'b0,
    CFG_EVICT_PERIOD = 1'b1
  } cfg_idx_t;

  // Per-group control for one item, already gated by the item stage
  typedef struct packed {
    logic  tick;
    logic  admit_fire;
    logic  evict_fire;
    logic  entry_free;
    logic  remove;
    slot_t rm_slot;
  } grp_ctl_t;

  // Per-group status for one item
  typedef struct packed {
    logic  admitted;
    logic  evicted;
    logic  removed;
    logic  found;
    slot_t next_idx;
  } grp_stat_t;

endpackage

// ----- hdl/tgrr_timer.sv -----
// Periodic tick timer: fires at zero, counts up and wraps at its period.
// Depends on tgrr_pkg.
module tgrr_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [tgrr_pkg::PERIOD_W-1:0] period,
  output logic                          fire
);
  import tgrr_pkg::*;

  logic [PERIOD_W-1:0] cnt_r;
  logic [PERIOD_W-1:0] cnt_nxt;
  logic [PERIOD_W-1:0] eff_period;
  logic [PERIOD_W:0]   incr;

  assign fire = (cnt_r == '0);

  // A zero period behaves as a period of one
  always_comb begin
    eff_period = (period == '0) ? PERIOD_W'(1) : period;
    incr = {1'b0, cnt_r} + (PERIOD_W + 1)'(1);
    if (!advance) begin
      cnt_nxt = cnt_r;
    end else if (incr >= {1'b0, eff_period}) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = incr[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/tgrr_group.sv -----
// One task group: active mask, age order, live count and round-robin pointer,
// with the admit / evict / remove update and the next-active search.
// Depends on tgrr_pkg.
module tgrr_group (
  input  logic                clk,
  input  logic                rst_n,
  input  tgrr_pkg::grp_ctl_t  ctl,
  input  logic                take,
  output tgrr_pkg::grp_stat_t stat
);
  import tgrr_pkg::*;

  localparam int S = SLOTS_PER_GROUP;
  localparam int SUM_W = SLOT_W + 1;

  typedef logic [S-1:0] mask_t;
  typedef slot_t [S-1:0] age_t;

  typedef struct packed {
    mask_t mask;
    age_t  age;
    slot_t cnt;
  } gst_t;

  gst_t  st_r;
  gst_t  st_nxt;
  slot_t ptr_r;
  slot_t ptr_nxt;

  // status bits, gathered into stat in one place
  logic  adm_c;
  logic  ev_c;
  logic  rem_c;
  logic  found_c;
  slot_t next_idx_c;

  // Activate the lowest free slot and append it to the age order
  function automatic gst_t admit_step(input gst_t s, input logic en, output logic ok);
    gst_t  r;
    logic  hit;
    slot_t sel;
    r   = s;
    hit = 1'b0;
    sel = '0;
    ok  = 1'b0;
    if (en && (s.cnt < SLOT_W'(S))) begin
      for (int i = 0; i < S; i++) begin
        if (!hit && !s.mask[i]) begin
          hit       = 1'b1;
          r.mask[i] = 1'b1;
          sel       = SLOT_W'(i);
        end
      end
      if (hit) begin
        for (int h = 0; h < S; h++) begin
          if (SLOT_W'(h) == s.cnt) begin
            r.age[h] = sel;
          end
        end
        r.cnt = s.cnt + SLOT_W'(1);
        ok    = 1'b1;
      end
    end
    return r;
  endfunction

  // Evict the oldest task of a full group
  function automatic gst_t evict_step(input gst_t s, input logic en, output logic ok);
    gst_t r;
    r  = s;
    ok = 1'b0;
    if (en && (s.cnt >= SLOT_W'(S))) begin
      ok = 1'b1;
      for (int i = 0; i < S; i++) begin
        if (s.age[0] == SLOT_W'(i)) begin
          r.mask[i] = 1'b0;
        end
      end
      for (int h = 0; h < S - 1; h++) begin
        r.age[h] = s.age[h+1];
      end
      r.age[S-1] = SLOT_EMPTY;
      r.cnt = s.cnt - SLOT_W'(1);
    end
    return r;
  endfunction

  // Deactivate one slot and drop its entry from the age order
  function automatic gst_t remove_step(input gst_t s, input logic en, input slot_t slot,
                                       output logic ok);
    gst_t r;
    logic hit;
    logic sh;
    r   = s;
    hit = 1'b0;
    sh  = 1'b0;
    for (int i = 0; i < S; i++) begin
      if ((slot == SLOT_W'(i)) && s.mask[i]) begin
        hit = 1'b1;
      end
    end
    ok = en && hit;
    if (en && hit) begin
      for (int i = 0; i < S; i++) begin
        if (slot == SLOT_W'(i)) begin
          r.mask[i] = 1'b0;
        end
      end
      // first matching live entry and everything younger shift down
      for (int h = 0; h < S - 1; h++) begin
        if ((SLOT_W'(h) < s.cnt) && (s.age[h] == slot)) begin
          sh = 1'b1;
        end
        if (sh) begin
          r.age[h] = s.age[h+1];
        end
      end
      if ((SLOT_W'(S - 1) < s.cnt) && (s.age[S-1] == slot)) begin
        sh = 1'b1;
      end
      if (sh) begin
        r.age[S-1] = SLOT_EMPTY;
      end
      if (s.cnt != '0) begin
        r.cnt = s.cnt - SLOT_W'(1);
      end
    end
    return r;
  endfunction

  // Tick path: admit, evict, re-admit; remove path stands beside it
  always_comb begin
    gst_t s1;
    gst_t s2;
    gst_t s3;
    gst_t sr;
    logic adm1;
    logic adm2;
    logic ev;
    logic rem;
    s1 = admit_step(st_r, ctl.tick && ctl.admit_fire && ctl.entry_free, adm1);
    s2 = evict_step(s1, ctl.tick && ctl.evict_fire, ev);
    s3 = admit_step(s2, ev && !adm1 && ctl.entry_free, adm2);
    sr = remove_step(st_r, ctl.remove, ctl.rm_slot, rem);
    st_nxt = ctl.remove ? sr : s3;
    adm_c  = adm1 | adm2;
    ev_c   = ev;
    rem_c  = rem;
  end

  // Next active slot after the pointer, wrapping, on the updated mask
  always_comb begin
    logic [SUM_W-1:0] c;
    logic             hit;
    hit = 1'b0;
    next_idx_c = '0;
    for (int i = 1; i <= S; i++) begin
      c = {1'b0, ptr_r} + SUM_W'(i);
      if (c >= SUM_W'(S)) begin
        c = c - SUM_W'(S);
      end
      for (int j = 0; j < S; j++) begin
        if (!hit && (c == SUM_W'(j)) && st_nxt.mask[j]) begin
          hit = 1'b1;
          next_idx_c = SLOT_W'(j);
        end
      end
    end
    found_c = hit;
  end

  assign stat = '{admitted: adm_c, evicted: ev_c, removed: rem_c, found: found_c,
                  next_idx: next_idx_c};

  assign ptr_nxt = take ? next_idx_c : ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mask <= '0;
      st_r.cnt  <= '0;
      for (int h = 0; h < S; h++) begin
        st_r.age[h] <= SLOT_EMPTY;
      end
      ptr_r <= '0;
    end else begin
      st_r  <= st_nxt;
      ptr_r <= ptr_nxt;
    end
  end

endmodule

// ----- hdl/two_group_round_robin_task_scheduler_core.sv -----
// Two-group round-robin task scheduler: two five-slot groups with timed
// admission, timed eviction of the oldest task, remove operations, and a
// round-robin pick that alternates between the groups.
// Depends on tgrr_pkg, tgrr_timer and tgrr_group.
//
// Each item (a scheduling tick or a remove) is taken into an input register
// and its result is loaded into the output register, raising out_valid, once
// that register is free or its result is being drained. One item is accepted
// every clock cycle for as long as results are drained; the figure is set by
// the combinational group update (admit, evict, re-admit, then the five-slot
// next-active search) between the input and output registers. A waiting
// result does not block the next item from entering the input register.
// Both timers start at zero, so both fire on the first tick. The period
// registers reset to 401 and 2001 ticks and are written through the cfg port,
// which is always ready; write it only while no item is in flight.
module two_group_round_robin_task_scheduler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // item input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic                          in_halt,
  input  logic                          in_entry_free_a,
  input  logic                          in_entry_free_b,
  input  logic                          in_target_group,
  input  logic [tgrr_pkg::SLOT_W-1:0]   in_target_slot,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_run_group,
  output logic [tgrr_pkg::SLOT_W-1:0]   out_run_slot,
  output logic                          out_run_idle,
  output logic                          out_admitted_a,
  output logic                          out_admitted_b,
  output logic                          out_evicted_a,
  output logic                          out_evicted_b,
  output logic                          out_removed,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [tgrr_pkg::PERIOD_W-1:0] cfg_data
);
  import tgrr_pkg::*;

  // configuration registers
  logic [PERIOD_W-1:0] admit_period_r;
  logic [PERIOD_W-1:0] evict_period_r;

  // input stage
  logic    in_v_r;
  logic    in_v_nxt;
  opcode_t opcode_r;
  logic    halt_r;
  logic    free_a_r;
  logic    free_b_r;
  logic    tgroup_r;
  slot_t   tslot_r;

  // output stage
  logic  out_valid_r;
  logic  out_valid_nxt;
  logic  run_group_r;
  slot_t run_slot_r;
  logic  run_idle_r;
  logic  adm_a_r;
  logic  adm_b_r;
  logic  ev_a_r;
  logic  ev_b_r;
  logic  rem_r;

  logic      last_was_a_r;
  logic      last_was_a_nxt;
  logic      adv;
  logic      tick;
  logic      rmv;
  logic      admit_fire;
  logic      evict_fire;
  logic      take_a;
  logic      take_b;
  grp_ctl_t  ctl_a;
  grp_ctl_t  ctl_b;
  grp_stat_t stat_a;
  grp_stat_t stat_b;
  slot_t     run_slot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      admit_period_r <= ADMIT_PERIOD_RESET;
      evict_period_r <= EVICT_PERIOD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ADMIT_PERIOD) begin
        admit_period_r <= cfg_data;
      end
      if (cfg_index == CFG_EVICT_PERIOD) begin
        evict_period_r <= cfg_data;
      end
    end
  end

  // Handshake: the held item moves on when the output register is free
  assign adv      = in_v_r && (!out_valid_r || out_ready);
  assign in_ready = !in_v_r || adv;

  always_comb begin
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opcode_r <= opcode_t'(in_opcode);
      halt_r   <= in_halt;
      free_a_r <= in_entry_free_a;
      free_b_r <= in_entry_free_b;
      tgroup_r <= in_target_group;
      tslot_r  <= in_target_slot;
    end
  end

  // Decode the item; halt suppresses everything
  assign tick = adv && !halt_r && (opcode_r == OP_TICK);
  assign rmv  = adv && !halt_r && (opcode_r == OP_REMOVE);

  tgrr_timer u_admit_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (tick),
    .period  (admit_period_r),
    .fire    (admit_fire)
  );

  tgrr_timer u_evict_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (tick),
    .period  (evict_period_r),
    .fire    (evict_fire)
  );

  always_comb begin
    ctl_a.tick       = tick;
    ctl_a.admit_fire = admit_fire;
    ctl_a.evict_fire = evict_fire;
    ctl_a.entry_free = free_a_r;
    ctl_a.remove     = rmv && !tgroup_r;
    ctl_a.rm_slot    = tslot_r;
    ctl_b.tick       = tick;
    ctl_b.admit_fire = admit_fire;
    ctl_b.evict_fire = evict_fire;
    ctl_b.entry_free = free_b_r;
    ctl_b.remove     = rmv && tgroup_r;
    ctl_b.rm_slot    = tslot_r;
  end

  tgrr_group u_group_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_a),
    .take  (take_a),
    .stat  (stat_a)
  );

  tgrr_group u_group_b (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_b),
    .take  (take_b),
    .stat  (stat_b)
  );

  // Group pick: the other group first, then the same one again
  assign take_b = tick && stat_b.found && (last_was_a_r || !stat_a.found);
  assign take_a = tick && stat_a.found && (!last_was_a_r || !stat_b.found);

  always_comb begin
    if (take_b) begin
      last_was_a_nxt = 1'b0;
      run_slot       = stat_b.next_idx;
    end else if (take_a) begin
      last_was_a_nxt = 1'b1;
      run_slot       = stat_a.next_idx;
    end else begin
      last_was_a_nxt = last_was_a_r;
      run_slot       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_was_a_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      last_was_a_r <= last_was_a_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv) begin
      run_group_r <= take_b;
      run_slot_r  <= run_slot;
      run_idle_r  <= !(take_a || take_b);
      adm_a_r     <= stat_a.admitted;
      adm_b_r     <= stat_b.admitted;
      ev_a_r      <= stat_a.evicted;
      ev_b_r      <= stat_b.evicted;
      rem_r       <= stat_a.removed || stat_b.removed;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_run_group  = run_group_r;
  assign out_run_slot   = run_slot_r;
  assign out_run_idle   = run_idle_r;
  assign out_admitted_a = adm_a_r;
  assign out_admitted_b = adm_b_r;
  assign out_evicted_a  = ev_a_r;
  assign out_evicted_b  = ev_b_r;
  assign out_removed    = rem_r;

  // Checks
  a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({take_a, take_b}))
    else $error("both groups picked for one item");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && halt_r) |=> (run_idle_r && !adm_a_r && !adm_b_r && !ev_a_r && !ev_b_r && !rem_r))
    else $error("halted item changed scheduling state");

  a_remove_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rem_r) |-> (run_idle_r && !adm_a_r && !adm_b_r && !ev_a_r && !ev_b_r))
    else $error("remove result carries tick flags");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !run_idle_r) |-> (run_slot_r < SLOT_EMPTY))
    else $error("chosen slot out of range");

endmodule
